/* hdl/assert_macros.svh */
// Assertion shorthands for the RTL files; ini_line_classifier includes them.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/ilc_pkg.sv */
package ilc_pkg;

	// Default line buffer size; at most MAX_LINE - 1 characters are kept.
	localparam int MAX_LINE_DEF = 256;

	// Characters with a meaning in an INI line.
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_EQUAL = 8'h3D;

	// Kind of the first non-space character of the line.
	localparam logic [1:0] MARK_NONE  = 2'd0;
	localparam logic [1:0] MARK_SEMI  = 2'd1;
	localparam logic [1:0] MARK_OPEN  = 2'd2;
	localparam logic [1:0] MARK_OTHER = 2'd3;

	// Line type codes.
	localparam logic [2:0] LT_INVALID = 3'd0;
	localparam logic [2:0] LT_EMPTY   = 3'd1;
	localparam logic [2:0] LT_COMMENT = 3'd2;
	localparam logic [2:0] LT_SECTION = 3'd3;
	localparam logic [2:0] LT_PAIR    = 3'd4;

	// Output item width on the bus, rounded up to whole bytes.
	localparam int TDATA_W = 64;

	// Sticky flags gathered while the line is scanned.
	typedef struct packed {
		logic tag_ok;       // '=' seen after some non-space character
		logic first_close;  // first non-space after '[' was ']'
		logic raw_close;    // ']' after the section name start
		logic strip_close;  // same, before any ';'
		logic raw_print;    // printable character after '='
		logic strip_print;  // same, before any ';'
		logic last_close;   // last non-space before ';' is ']'
		logic too_long;     // characters were dropped
	} ilc_flags_t;

	// One result item; the last field sits in the lowest bits.
	typedef struct packed {
		logic [7:0] value_len;
		logic [7:0] value_start;
		logic [7:0] tag_len;
		logic       pair_ok;
		logic [7:0] section_len;
		logic [7:0] section_start;
		logic       section_ok;
		logic [7:0] comment_start;
		logic       too_long;
		logic [7:0] line_len;
		logic [2:0] line_type;
	} ilc_result_t;

	localparam int RES_W = $bits(ilc_result_t);

	function automatic logic is_space(input logic [7:0] c);
		return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return (c >= 8'h20) && (c <= 8'h7E);
	endfunction

endpackage

/* hdl/ini_line_classifier.sv */
// Result: a terminator passes the input register and then the result register; it waits in
// the input register while an earlier result still waits in the result register.
// Throughput: one item per cycle; a character is scanned in one step of the line state.
// A waiting result stalls only the next terminator, and the input behind it.
// Reset: arst_n clears the line state and the valid flags of the input stage and the
// result register at once; s_tready is high as soon as reset has cleared the input stage.
`include "assert_macros.svh"

module ini_line_classifier #(
	parameter int MAX_LINE = ilc_pkg::MAX_LINE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,   // ch[7:0]
	input  logic                        s_tlast,   // end_of_line
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// line_type[2:0], line_len[10:3], too_long[11], comment_start[19:12],
	// section_ok[20], section_start[28:21], section_len[36:29], pair_ok[37],
	// tag_len[45:38], value_start[53:46], value_len[61:54], zero[63:62]
	output logic [ilc_pkg::TDATA_W-1:0] m_tdata
);
	import ilc_pkg::*;

	localparam int PW = $clog2(MAX_LINE);

	logic          v_s1, eol_s1;
	logic [7:0]    ch_s1;
	logic          advance;
	logic          m_tvalid_q;
	ilc_result_t   res_q, res;

	logic [PW-1:0] pos, semi, eq, ln0, ln1, tend, bs, vs;
	logic [1:0]    mark;
	logic          semi_v, eq_v, ln0_v, ln1_v, tend_v, bs_v, vs_v;
	ilc_flags_t    flags;

	// A character always moves on; a terminator waits for room in the result register.
	assign advance  = v_s1 && (!eol_s1 || !m_tvalid_q || m_tready);
	assign s_tready = !v_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1  <= s_tdata;
			eol_s1 <= s_tlast;
		end
	end

	ilc_scan #(.MAX_LINE(MAX_LINE)) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.eol    (eol_s1),
		.ch     (ch_s1),
		.pos    (pos),
		.mark   (mark),
		.semi_v (semi_v),
		.semi   (semi),
		.eq_v   (eq_v),
		.eq     (eq),
		.ln0_v  (ln0_v),
		.ln0    (ln0),
		.ln1_v  (ln1_v),
		.ln1    (ln1),
		.tend_v (tend_v),
		.tend   (tend),
		.bs_v   (bs_v),
		.bs     (bs),
		.vs_v   (vs_v),
		.vs     (vs),
		.flags  (flags)
	);

	ilc_classify #(.MAX_LINE(MAX_LINE)) u_classify (
		.pos    (pos),
		.mark   (mark),
		.semi_v (semi_v),
		.semi   (semi),
		.eq_v   (eq_v),
		.eq     (eq),
		.ln0_v  (ln0_v),
		.ln0    (ln0),
		.ln1_v  (ln1_v),
		.ln1    (ln1),
		.tend_v (tend_v),
		.tend   (tend),
		.bs_v   (bs_v),
		.bs     (bs),
		.vs_v   (vs_v),
		.vs     (vs),
		.flags  (flags),
		.res    (res)
	);

	// Result register, loaded when a terminator leaves the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (advance && eol_s1) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && eol_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(TDATA_W - RES_W)'(0), res_q};

	// A waiting result is never overwritten.
	`ASSERT_IMPLIES(a_no_overwrite, m_tvalid_q && !m_tready, !(advance && eol_s1), "result overwritten")
	// A terminator leaves the line state cleared.
	`ASSERT_NEXT(a_line_cleared, advance && eol_s1, pos == '0 && mark == MARK_NONE, "line state not cleared")
	// A stripped line is never both a section and a pair.
	`ASSERT_IMPLIES(a_sec_xor_pair, m_tvalid_q, !(res_q.section_ok && res_q.pair_ok), "section and pair both set")

endmodule

/* hdl/ilc_scan.sv */
module ilc_scan #(
	parameter int MAX_LINE = ilc_pkg::MAX_LINE_DEF,
	localparam int PW = $clog2(MAX_LINE)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic                eol,
	input  logic [7:0]          ch,
	output logic [PW-1:0]       pos,
	output logic [1:0]          mark,
	output logic                semi_v,
	output logic [PW-1:0]       semi,
	output logic                eq_v,
	output logic [PW-1:0]       eq,
	output logic                ln0_v,
	output logic [PW-1:0]       ln0,
	output logic                ln1_v,
	output logic [PW-1:0]       ln1,
	output logic                tend_v,
	output logic [PW-1:0]       tend,
	output logic                bs_v,
	output logic [PW-1:0]       bs,
	output logic                vs_v,
	output logic [PW-1:0]       vs,
	output ilc_pkg::ilc_flags_t flags
);
	import ilc_pkg::*;

	localparam logic [PW-1:0] POS_LAST = PW'(MAX_LINE - 1);

	logic [PW-1:0] pos_q, semi_q, eq_q, ln0_q, ln1_q, tend_q, bs_q, vs_q;
	logic [1:0]    mark_q;
	logic          semi_v_q, eq_v_q, ln0_v_q, ln1_v_q, tend_v_q, bs_v_q, vs_v_q;
	ilc_flags_t    flags_q;

	logic in_strip, printable, after_eq, non_space, after_bs;

	// Character classes against the current line state.
	always_comb begin
		in_strip  = !semi_v_q && (ch != CH_SEMI);
		printable = is_print(ch);
		after_eq  = eq_v_q && (pos_q > eq_q);
		non_space = !is_space(ch);
		after_bs  = bs_v_q && (pos_q > bs_q);
	end

	// Line state: updated on each kept character, too_long set on a dropped one, cleared by the terminator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			mark_q   <= MARK_NONE;
			semi_v_q <= 1'b0;
			semi_q   <= '0;
			eq_v_q   <= 1'b0;
			eq_q     <= '0;
			ln0_v_q  <= 1'b0;
			ln0_q    <= '0;
			ln1_v_q  <= 1'b0;
			ln1_q    <= '0;
			tend_v_q <= 1'b0;
			tend_q   <= '0;
			bs_v_q   <= 1'b0;
			bs_q     <= '0;
			vs_v_q   <= 1'b0;
			vs_q     <= '0;
			flags_q  <= '0;
		end else if (take) begin
			if (eol) begin
				pos_q    <= '0;
				mark_q   <= MARK_NONE;
				semi_v_q <= 1'b0;
				eq_v_q   <= 1'b0;
				ln0_v_q  <= 1'b0;
				ln1_v_q  <= 1'b0;
				tend_v_q <= 1'b0;
				bs_v_q   <= 1'b0;
				vs_v_q   <= 1'b0;
				flags_q  <= '0;
			end else if (pos_q < POS_LAST) begin
				pos_q <= pos_q + 1'b1;
				if (printable && after_eq) begin
					flags_q.raw_print <= 1'b1;
					if (in_strip) begin
						flags_q.strip_print <= 1'b1;
					end
				end
				if (non_space) begin
					// First '=' splits tag from value.
					if ((ch == CH_EQUAL) && !eq_v_q) begin
						eq_v_q   <= 1'b1;
						eq_q     <= pos_q;
						tend_v_q <= ln0_v_q;
						tend_q   <= ln0_q;
						if (mark_q != MARK_NONE) begin
							flags_q.tag_ok <= 1'b1;
						end
					end
					// Kind of the first non-space, then start of the section name.
					if (mark_q == MARK_NONE) begin
						priority if (ch == CH_SEMI) begin
							mark_q <= MARK_SEMI;
						end else if (ch == CH_OPEN) begin
							mark_q <= MARK_OPEN;
						end else begin
							mark_q <= MARK_OTHER;
						end
					end else if ((mark_q == MARK_OPEN) && !bs_v_q) begin
						bs_v_q <= 1'b1;
						bs_q   <= pos_q;
						if (ch == CH_CLOSE) begin
							flags_q.first_close <= 1'b1;
						end
					end
					if ((ch == CH_CLOSE) && after_bs) begin
						flags_q.raw_close <= 1'b1;
						if (in_strip) begin
							flags_q.strip_close <= 1'b1;
						end
					end
					// Trailing non-space tracking before any comment.
					if (in_strip) begin
						ln1_v_q            <= ln0_v_q;
						ln1_q              <= ln0_q;
						ln0_v_q            <= 1'b1;
						ln0_q              <= pos_q;
						flags_q.last_close <= (ch == CH_CLOSE);
						if (after_eq && !vs_v_q) begin
							vs_v_q <= 1'b1;
							vs_q   <= pos_q;
						end
					end else if ((ch == CH_SEMI) && !semi_v_q) begin
						semi_v_q <= 1'b1;
						semi_q   <= pos_q;
					end
				end
			end else begin
				flags_q.too_long <= 1'b1;
			end
		end
	end

	assign pos    = pos_q;
	assign mark   = mark_q;
	assign semi_v = semi_v_q;
	assign semi   = semi_q;
	assign eq_v   = eq_v_q;
	assign eq     = eq_q;
	assign ln0_v  = ln0_v_q;
	assign ln0    = ln0_q;
	assign ln1_v  = ln1_v_q;
	assign ln1    = ln1_q;
	assign tend_v = tend_v_q;
	assign tend   = tend_q;
	assign bs_v   = bs_v_q;
	assign bs     = bs_q;
	assign vs_v   = vs_v_q;
	assign vs     = vs_q;
	assign flags  = flags_q;

endmodule

/* hdl/ilc_classify.sv */
module ilc_classify #(
	parameter int MAX_LINE = ilc_pkg::MAX_LINE_DEF,
	localparam int PW = $clog2(MAX_LINE)
) (
	input  logic [PW-1:0]        pos,
	input  logic [1:0]           mark,
	input  logic                 semi_v,
	input  logic [PW-1:0]        semi,
	input  logic                 eq_v,
	input  logic [PW-1:0]        eq,
	input  logic                 ln0_v,
	input  logic [PW-1:0]        ln0,
	input  logic                 ln1_v,
	input  logic [PW-1:0]        ln1,
	input  logic                 tend_v,
	input  logic [PW-1:0]        tend,
	input  logic                 bs_v,
	input  logic [PW-1:0]        bs,
	input  logic                 vs_v,
	input  logic [PW-1:0]        vs,
	input  ilc_pkg::ilc_flags_t  flags,
	output ilc_pkg::ilc_result_t res
);
	import ilc_pkg::*;

	// Wide enough for any offset plus one, and for the 8-bit output fields.
	localparam int XW = (PW + 1 > 8) ? PW + 1 : 8;

	logic [PW-1:0] strip_end;
	logic          strip_sec, sec_ok, pair_ok, val_ok;
	logic [XW-1:0] len_x, cs_x, ss_x, sl_x, tl_x, vst_x, vl_x;

	// Section and pair tests on the comment-stripped line.
	always_comb begin
		strip_end = semi_v ? semi : pos;
		strip_sec = (mark == MARK_OPEN) && bs_v && (bs < strip_end) &&
			!flags.first_close && flags.strip_close;
		sec_ok    = strip_sec && flags.last_close && ln0_v && (ln0 > bs) &&
			ln1_v && (ln1 >= bs);
		pair_ok   = !strip_sec && eq_v && (eq < strip_end) && flags.tag_ok &&
			flags.strip_print && tend_v;
		val_ok    = pair_ok && vs_v && ln0_v && (ln0 >= vs);
	end

	// Offsets and lengths before truncation to the output fields.
	always_comb begin
		len_x = XW'(pos);
		cs_x  = XW'(strip_end);
		ss_x  = sec_ok ? XW'(bs) : '0;
		sl_x  = sec_ok ? XW'({1'b0, ln1} - {1'b0, bs} + 1'b1) : '0;
		tl_x  = pair_ok ? XW'({1'b0, tend} + 1'b1) : '0;
		vst_x = val_ok ? XW'(vs) : '0;
		vl_x  = val_ok ? XW'({1'b0, ln0} - {1'b0, vs} + 1'b1) : '0;
	end

	// Line type of the raw line, tested in order.
	always_comb begin
		res = '0;
		priority if (mark == MARK_NONE) begin
			res.line_type = LT_EMPTY;
		end else if (mark == MARK_SEMI) begin
			res.line_type = LT_COMMENT;
		end else if ((mark == MARK_OPEN) && bs_v && !flags.first_close && flags.raw_close) begin
			res.line_type = LT_SECTION;
		end else if (eq_v && flags.tag_ok && flags.raw_print) begin
			res.line_type = LT_PAIR;
		end else begin
			res.line_type = LT_INVALID;
		end
		res.line_len      = len_x[7:0];
		res.too_long      = flags.too_long;
		res.comment_start = cs_x[7:0];
		res.section_ok    = sec_ok;
		res.section_start = ss_x[7:0];
		res.section_len   = sl_x[7:0];
		res.pair_ok       = pair_ok;
		res.tag_len       = tl_x[7:0];
		res.value_start   = vst_x[7:0];
		res.value_len     = vl_x[7:0];
	end

endmodule
